// File: sv/lra_pkg.sv
// Shared types, widths and constants for the least-loaded row assignment unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package lra_pkg;

  localparam int MAX_ROWS   = 32;
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CNT_W      = 6;
  localparam int GAP_W      = 10;
  localparam int WIDTH_W    = 12;
  localparam int TOTAL_W    = 16;
  localparam int SUM_W      = TOTAL_W + 2;
  localparam int IDX_W      = 5;
  localparam int NUM_W      = (CNT_W > $clog2(MAX_ROWS + 1)) ? CNT_W : $clog2(MAX_ROWS + 1);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GAP_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAP       = CFG_IDX_W'(1);

  typedef struct packed {
    logic [WIDTH_W-1:0] item_width;
    logic               first;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]   row_index;
    logic               final_res;
    logic [TOTAL_W-1:0] max_total;
  } result_t;

  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    logic             clear;
  } rows_req_t;

  // Highest row index in use: zero count means one row, large counts clamp.
  function automatic logic [ROW_W-1:0] last_row_of(input logic [CNT_W-1:0] cnt);
    logic [NUM_W-1:0] c;
    c = NUM_W'(cnt);
    if (c == '0) return '0;
    if (c > NUM_W'(MAX_ROWS)) return ROW_W'(MAX_ROWS - 1);
    return ROW_W'(c - NUM_W'(1));
  endfunction

endpackage

// File: sv/lra_if.sv
// Valid/ready channel interfaces for item input and result output.
// Depends on lra_pkg for field widths.
`timescale 1ns / 1ps

interface lra_in_if;
  import lra_pkg::*;
  logic               valid;
  logic               ready;
  logic [WIDTH_W-1:0] item_width;
  logic               first;
  logic               last;

  modport source(output valid, output item_width, output first, output last, input ready);
  modport sink(input valid, input item_width, input first, input last, output ready);
endinterface

interface lra_out_if;
  import lra_pkg::*;
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   row_index;
  logic               final_res;
  logic [TOTAL_W-1:0] max_total;

  modport source(output valid, output row_index, output final_res, output max_total,
                 input ready);
  modport sink(input valid, input row_index, input final_res, input max_total,
               output ready);
endinterface

// File: sv/lra_rows.sv
// Row total store: memory with one read and one write port, registered read, per-row valid bits and a base value.
// Rows not written since the last restart read as the base. Depends on lra_pkg.
`timescale 1ns / 1ps

module lra_rows (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lra_pkg::rows_req_t      req,
  input  logic [lra_pkg::TOTAL_W-1:0] wr_data,
  input  logic [lra_pkg::GAP_W-1:0]   gap,
  output logic [lra_pkg::TOTAL_W-1:0] rd_data
);
  import lra_pkg::*;

  logic [TOTAL_W-1:0]  mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] valid_r;
  logic [TOTAL_W-1:0]  base_r;
  logic [TOTAL_W-1:0]  mq_r;
  logic                vq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      base_r  <= '0;
    end else begin
      if (req.clear) begin
        valid_r <= '0;
        base_r  <= TOTAL_W'(gap);
      end
      if (req.wr_en) begin
        valid_r[req.wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= wr_data;
    end
    if (req.rd_en) begin
      mq_r <= mem[req.rd_addr];
      vq_r <= valid_r[req.rd_addr];
    end
  end

  assign rd_data = vq_r ? mq_r : base_r;

endmodule

// File: sv/lra_seq.sv
// Sequencer and shared compare/add unit: scans the rows in use for the minimum
// and maximum totals, then updates the chosen row. Depends on lra_pkg.
`timescale 1ns / 1ps

module lra_seq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  lra_pkg::item_t              item,
  input  logic [lra_pkg::CNT_W-1:0]   row_count,
  input  logic [lra_pkg::GAP_W-1:0]   gap,
  output lra_pkg::rows_req_t          req,
  output logic [lra_pkg::TOTAL_W-1:0] wr_data,
  input  logic [lra_pkg::TOTAL_W-1:0] rd_data,
  output logic                        res_valid,
  output lra_pkg::result_t            res,
  input  logic                        res_free
);
  import lra_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_LAST, S_UPD, S_DONE} state_t;

  state_t             state_r;
  item_t              item_r;
  logic [ROW_W-1:0]   last_row_r;
  logic [ROW_W-1:0]   rd_idx_r;
  logic               pend_r;
  logic [ROW_W-1:0]   pend_idx_r;
  logic [ROW_W-1:0]   best_idx_r;
  logic [TOTAL_W-1:0] best_val_r;
  logic [TOTAL_W-1:0] max_val_r;
  result_t            res_r;

  logic               accept;
  logic               cmp_first;
  logic               cmp_lt;
  logic               cmp_gt;
  logic [SUM_W-1:0]   sum;
  logic [TOTAL_W-1:0] sat_sum;
  logic [TOTAL_W-1:0] top;

  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  // shared compare unit
  assign cmp_first = (pend_idx_r == '0);
  assign cmp_lt    = rd_data < best_val_r;
  assign cmp_gt    = rd_data > max_val_r;

  // shared add/saturate unit
  assign sum     = SUM_W'(best_val_r) + SUM_W'(item_r.item_width) + SUM_W'(gap);
  assign sat_sum = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
  assign top     = (sat_sum > max_val_r) ? sat_sum : max_val_r;
  assign wr_data = sat_sum;

  always_comb begin
    req.rd_en   = (state_r == S_SCAN);
    req.rd_addr = rd_idx_r;
    req.wr_en   = (state_r == S_UPD);
    req.wr_addr = best_idx_r;
    req.clear   = accept && item.first;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      unique case (state_r) inside
        S_IDLE: begin
          if (accept) begin
            item_r     <= item;
            last_row_r <= last_row_of(row_count);
            rd_idx_r   <= '0;
            pend_r     <= 1'b0;
            state_r    <= S_SCAN;
          end
        end
        S_SCAN, S_LAST: begin
          if (pend_r) begin
            if (cmp_first || cmp_lt) begin
              best_idx_r <= pend_idx_r;
              best_val_r <= rd_data;
            end
            if (cmp_first || cmp_gt) begin
              max_val_r <= rd_data;
            end
          end
          pend_idx_r <= rd_idx_r;
          if (state_r == S_SCAN) begin
            pend_r <= 1'b1;
            if (rd_idx_r == last_row_r) begin
              state_r <= S_LAST;
            end else begin
              rd_idx_r <= rd_idx_r + ROW_W'(1);
            end
          end else begin
            pend_r  <= 1'b0;
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          res_r.row_index <= IDX_W'(best_idx_r);
          res_r.final_res <= item_r.last;
          res_r.max_total <= item_r.last ? top : '0;
          state_r         <= S_DONE;
        end
        S_DONE: begin
          if (res_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: sv/least_loaded_row_assignment_unit.sv
// Top level of the least-loaded row assignment unit: config registers, output register.
// Depends on lra_pkg, lra_if, lra_rows and lra_seq.
//
// Usage:
//   in_ch  (sink): one item per handshake: item_width, first, last.
//   out_ch (source): one result per item: row_index, final_res, max_total.
//   cfg_we/cfg_idx/cfg_data: register 0 is row_count, register 1 is gap;
//   other indexes are ignored. Write only while the block is idle.
// Flow: the row totals of the rows in use are read once each through the single
//   memory read port, then the chosen row is updated. The finished result is
//   loaded into the output register once that register is free, and is presented
//   on out_ch from that register.
// An item with first set restarts every row total at gap as the item is accepted.
// Reset: row totals read as zero, row_count = 1, gap = 0, no result pending.
// Stall: the result sits in the output register; the next item is accepted and
//   processed meanwhile, and only its result waits for the register to drain.
`timescale 1ns / 1ps

module least_loaded_row_assignment_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  lra_in_if.sink                        in_ch,
  lra_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [lra_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lra_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lra_pkg::*;

  logic [CNT_W-1:0]   row_count_r;
  logic [GAP_W-1:0]   gap_r;
  item_t              item;
  rows_req_t          req;
  logic [TOTAL_W-1:0] wr_data;
  logic [TOTAL_W-1:0] rd_data;
  logic               res_valid;
  result_t            res;
  logic               res_free;
  logic               out_valid_r;
  result_t            out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CNT_W'(1);
      gap_r       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_ROW_COUNT: row_count_r <= cfg_data[CNT_W-1:0];
        REG_GAP:       gap_r       <= cfg_data[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign item.item_width = in_ch.item_width;
  assign item.first      = in_ch.first;
  assign item.last       = in_ch.last;

  lra_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .item      (item),
    .row_count (row_count_r),
    .gap       (gap_r),
    .req       (req),
    .wr_data   (wr_data),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free)
  );

  lra_rows u_rows (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .wr_data (wr_data),
    .gap     (gap_r),
    .rd_data (rd_data)
  );

  assign res_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_free) begin
      out_valid_r <= 1'b1;
      out_r       <= res;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.row_index = out_r.row_index;
  assign out_ch.final_res = out_r.final_res;
  assign out_ch.max_total = out_r.max_total;

  a_max_only_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.final_res |-> out_ch.max_total == '0)
    else $error("max_total nonzero on a non-final result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input ready right after an accepted item");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_free |=> out_ch.valid)
    else $error("finished result not presented on output");

  a_no_write_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !(req.wr_en && (req.clear || req.rd_en)))
    else $error("row write overlaps a restart or a read");

endmodule
